// ===== hdl/stb_pkg.sv =====
// shared types, character codes and token kinds of the source byte tokenizer
`default_nettype none

package stb_pkg;

  // default width of number tokens
  localparam int unsigned NUMBER_BITS_DEF = 31;

  // result queue depth (one byte may push two results)
  localparam int unsigned RES_DEPTH = 4;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // compare operator index held while waiting for a trailing '='
  localparam logic [1:0] CMP_EQ   = 2'd0;
  localparam logic [1:0] CMP_LT   = 2'd1;
  localparam logic [1:0] CMP_GT   = 2'd2;
  localparam logic [1:0] CMP_BANG = 2'd3;

  // error codes
  localparam logic ERR_UNKNOWN = 1'b0;
  localparam logic ERR_UNTERM  = 1'b1;

  typedef enum logic [4:0] {
    KIND_STR    = 5'd0,
    KIND_NUM    = 5'd1,
    KIND_IDENT  = 5'd2,
    KIND_PLUS   = 5'd3,
    KIND_MINUS  = 5'd4,
    KIND_STAR   = 5'd5,
    KIND_SLASH  = 5'd6,
    KIND_PCT    = 5'd7,
    KIND_ASSIGN = 5'd8,
    KIND_LT     = 5'd9,
    KIND_GT     = 5'd10,
    KIND_BANG   = 5'd11,
    KIND_COMMA  = 5'd12,
    KIND_PIPE   = 5'd13,
    KIND_EQEQ   = 5'd14,
    KIND_NE     = 5'd15,
    KIND_LE     = 5'd16,
    KIND_GE     = 5'd17,
    KIND_LPAR   = 5'd18,
    KIND_RPAR   = 5'd19,
    KIND_LBRACE = 5'd20,
    KIND_RBRACE = 5'd21,
    KIND_NL     = 5'd22,
    KIND_SEMI   = 5'd23,
    KIND_EOF    = 5'd24
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_WHOLE = 2'd0,
    ROLE_TEXT  = 2'd1,
    ROLE_END   = 2'd2,
    ROLE_ERR   = 2'd3
  } role_e;

  // one result without its number value
  typedef struct packed {
    kind_e      kind;
    role_e      role;
    logic [7:0] text_char;
    logic       clipped;
    logic       err_code;
    logic       last;
  } res_meta_t;

  localparam res_meta_t RES_NONE = '{
    kind: KIND_STR, role: ROLE_WHOLE, text_char: 8'h00,
    clipped: 1'b0, err_code: 1'b0, last: 1'b0
  };

  // kind of a lone compare operator
  function automatic kind_e cmp_single(input logic [1:0] idx);
    kind_e k;
    case (idx)
      CMP_EQ:  k = KIND_ASSIGN;
      CMP_LT:  k = KIND_LT;
      CMP_GT:  k = KIND_GT;
      default: k = KIND_BANG;
    endcase
    return k;
  endfunction

  // kind of a compare operator followed by '='
  function automatic kind_e cmp_double(input logic [1:0] idx);
    kind_e k;
    case (idx)
      CMP_EQ:  k = KIND_EQEQ;
      CMP_LT:  k = KIND_LE;
      CMP_GT:  k = KIND_GE;
      default: k = KIND_NE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stb_if.sv =====
// valid/ready channel interfaces for source bytes and token results
`default_nettype none

interface stb_byte_if;
  import stb_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface stb_tok_if #(
  parameter int unsigned NUM_W = stb_pkg::NUMBER_BITS_DEF
);
  import stb_pkg::*;

  logic             valid;
  logic             ready;
  logic [4:0]       token_kind;
  logic [1:0]       result_role;
  logic [7:0]       text_char;
  logic [NUM_W-1:0] number_value;
  logic             number_clipped;
  logic             error_code;
  logic             last_of_item;

  modport source (
    output valid, output token_kind, output result_role, output text_char,
    output number_value, output number_clipped, output error_code,
    output last_of_item, input ready
  );
  modport sink (
    input valid, input token_kind, input result_role, input text_char,
    input number_value, input number_clipped, input error_code,
    input last_of_item, output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stb_scan.sv =====
// input byte register and scanner state machine, up to two results per byte
`default_nettype none

module stb_scan #(
  parameter int unsigned NUMBER_BITS = stb_pkg::NUMBER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [7:0]             in_byte_i,
  output logic                   in_ready_o,
  input  logic                   room_i,
  output logic [1:0]             push_cnt_o,
  output stb_pkg::res_meta_t     res0_o,
  output stb_pkg::res_meta_t     res1_o,
  output logic [NUMBER_BITS-1:0] val0_o
);
  import stb_pkg::*;

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_NUM   = 3'd1;
  localparam logic [2:0] MODE_IDENT = 3'd2;
  localparam logic [2:0] MODE_STR   = 3'd3;
  localparam logic [2:0] MODE_CMP   = 3'd4;
  localparam logic [2:0] MODE_HALT  = 3'd5;

  localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

  logic                   vld_q, vld_d;
  logic [7:0]             byte_q;
  logic [2:0]             mode_q, mode_d;
  logic [1:0]             pend_q, pend_d;
  logic [NUMBER_BITS-1:0] acc_q, acc_d;
  logic                   clip_q, clip_d;
  logic                   adv;

  // byte classes
  logic                   is_digit, is_alpha, is_blank;
  logic [3:0]             digit;

  // idle-start decode of the current byte
  logic [2:0]             idle_mode;
  logic                   idle_emit;
  res_meta_t              idle_res;
  logic [1:0]             idle_pend;

  // result emitted before the idle-start one
  logic                   pre_emit;
  res_meta_t              pre_res;
  logic [NUMBER_BITS-1:0] pre_val;
  logic                   use_idle;

  logic [NUMBER_BITS+3:0] acc_x10;
  logic                   acc_sat;

  assign adv        = vld_q & room_i;
  assign in_ready_o = ~vld_q | room_i;

  // input byte register
  assign vld_d = (in_valid_i & in_ready_o) | (vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  // byte classification
  always_comb begin
    is_digit = byte_q inside {[CH_ZERO:CH_NINE]};
    is_alpha = byte_q inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
    is_blank = byte_q inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
    digit    = 4'(byte_q - CH_ZERO);
  end

  // acc * 10 + digit with saturation
  always_comb begin
    acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NUMBER_BITS+4)'(digit);
    acc_sat = |acc_x10[NUMBER_BITS+3:NUMBER_BITS];
  end

  // what the byte does when no token is open
  always_comb begin
    idle_mode = MODE_IDLE;
    idle_emit = 1'b0;
    idle_res  = RES_NONE;
    idle_pend = pend_q;
    if (is_blank) begin
      idle_mode = MODE_IDLE;
    end else if (is_digit) begin
      idle_mode = MODE_NUM;
    end else if (is_alpha) begin
      idle_mode          = MODE_IDENT;
      idle_emit          = 1'b1;
      idle_res.kind      = KIND_IDENT;
      idle_res.role      = ROLE_TEXT;
      idle_res.text_char = byte_q;
    end else if (byte_q == CH_QUOTE) begin
      idle_mode = MODE_STR;
    end else begin
      idle_emit = 1'b1;
      case (byte_q)
        CH_EQ: begin
          idle_mode = MODE_CMP; idle_emit = 1'b0; idle_pend = CMP_EQ;
        end
        CH_LT: begin
          idle_mode = MODE_CMP; idle_emit = 1'b0; idle_pend = CMP_LT;
        end
        CH_GT: begin
          idle_mode = MODE_CMP; idle_emit = 1'b0; idle_pend = CMP_GT;
        end
        CH_BANG: begin
          idle_mode = MODE_CMP; idle_emit = 1'b0; idle_pend = CMP_BANG;
        end
        CH_PLUS:   idle_res.kind = KIND_PLUS;
        CH_MINUS:  idle_res.kind = KIND_MINUS;
        CH_STAR:   idle_res.kind = KIND_STAR;
        CH_SLASH:  idle_res.kind = KIND_SLASH;
        CH_PCT:    idle_res.kind = KIND_PCT;
        CH_COMMA:  idle_res.kind = KIND_COMMA;
        CH_PIPE:   idle_res.kind = KIND_PIPE;
        CH_LPAR:   idle_res.kind = KIND_LPAR;
        CH_RPAR:   idle_res.kind = KIND_RPAR;
        CH_LBRACE: idle_res.kind = KIND_LBRACE;
        CH_RBRACE: idle_res.kind = KIND_RBRACE;
        CH_LF:     idle_res.kind = KIND_NL;
        CH_SEMI:   idle_res.kind = KIND_SEMI;
        CH_NUL:    idle_res.kind = KIND_EOF;
        default: begin
          // byte that starts no token
          idle_mode         = MODE_HALT;
          idle_res.role     = ROLE_ERR;
          idle_res.err_code = ERR_UNKNOWN;
        end
      endcase
    end
  end

  // scanner next state and the closing result of an open token
  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    clip_d   = clip_q;
    pre_emit = 1'b0;
    pre_res  = RES_NONE;
    pre_val  = '0;
    use_idle = 1'b0;
    case (mode_q)
      MODE_HALT: begin
        mode_d = MODE_HALT;
      end
      MODE_NUM: begin
        if (is_digit) begin
          if (acc_sat) begin
            acc_d  = NUM_MAX;
            clip_d = 1'b1;
          end else begin
            acc_d = acc_x10[NUMBER_BITS-1:0];
          end
        end else begin
          pre_emit        = 1'b1;
          pre_res.kind    = KIND_NUM;
          pre_res.clipped = clip_q;
          pre_val         = acc_q;
          use_idle        = 1'b1;
        end
      end
      MODE_IDENT: begin
        pre_emit     = 1'b1;
        pre_res.kind = KIND_IDENT;
        if (is_alpha || is_digit) begin
          pre_res.role      = ROLE_TEXT;
          pre_res.text_char = byte_q;
        end else begin
          pre_res.role = ROLE_END;
          use_idle     = 1'b1;
        end
      end
      MODE_STR: begin
        pre_emit = 1'b1;
        if (byte_q == CH_QUOTE) begin
          mode_d       = MODE_IDLE;
          pre_res.role = ROLE_END;
        end else if (byte_q == CH_NUL) begin
          mode_d           = MODE_HALT;
          pre_res.role     = ROLE_ERR;
          pre_res.err_code = ERR_UNTERM;
        end else begin
          pre_res.role      = ROLE_TEXT;
          pre_res.text_char = byte_q;
        end
      end
      MODE_CMP: begin
        pre_emit = 1'b1;
        if (byte_q == CH_EQ) begin
          mode_d       = MODE_IDLE;
          pre_res.kind = cmp_double(pend_q);
        end else begin
          pre_res.kind = cmp_single(pend_q);
          use_idle     = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase

    if (use_idle) begin
      mode_d = idle_mode;
      pend_d = idle_pend;
      if (is_digit) begin
        acc_d  = NUMBER_BITS'(digit);
        clip_d = 1'b0;
      end
    end
  end

  // pack the results for this byte, last flag on the final one
  always_comb begin
    push_cnt_o = 2'd0;
    res0_o     = RES_NONE;
    res1_o     = RES_NONE;
    val0_o     = '0;
    if (adv) begin
      if (pre_emit) begin
        res0_o = pre_res;
        val0_o = pre_val;
        if (use_idle && idle_emit) begin
          push_cnt_o  = 2'd2;
          res1_o      = idle_res;
          res1_o.last = 1'b1;
        end else begin
          push_cnt_o  = 2'd1;
          res0_o.last = 1'b1;
        end
      end else if (use_idle && idle_emit) begin
        push_cnt_o  = 2'd1;
        res0_o      = idle_res;
        res0_o.last = 1'b1;
      end
    end
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pend_q <= CMP_EQ;
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else if (adv) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      acc_q  <= acc_d;
      clip_q <= clip_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stb_resq.sv =====
// small result queue: up to two pushes and one pop per cycle
`default_nettype none

module stb_resq #(
  parameter int unsigned NUMBER_BITS = stb_pkg::NUMBER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [1:0]             push_cnt_i,
  input  stb_pkg::res_meta_t     res0_i,
  input  stb_pkg::res_meta_t     res1_i,
  input  logic [NUMBER_BITS-1:0] val0_i,
  output logic                   room_o,
  stb_tok_if.source              out_o
);
  import stb_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

  res_meta_t              meta_q [RES_DEPTH];
  logic [NUMBER_BITS-1:0] val_q  [RES_DEPTH];
  logic [PTR_W-1:0]       wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   pop;
  res_meta_t              head;

  // space for a full two-result byte
  assign room_o = cnt_q <= CNT_W'(RES_DEPTH - 2);
  assign pop    = out_o.valid & out_o.ready;
  assign wr_nx  = PTR_W'(wr_q + 1'b1);

  always_comb begin
    wr_d  = PTR_W'(wr_q + PTR_W'(push_cnt_i));
    rd_d  = pop ? PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = CNT_W'(cnt_q + CNT_W'(push_cnt_i) - CNT_W'(pop));
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      meta_q[wr_q] <= res0_i;
      val_q[wr_q]  <= val0_i;
    end
    if (push_cnt_i == 2'd2) begin
      meta_q[wr_nx] <= res1_i;
      val_q[wr_nx]  <= '0;
    end
  end

  // head of the queue drives the result channel
  assign head                 = meta_q[rd_q];
  assign out_o.valid          = cnt_q != '0;
  assign out_o.token_kind     = head.kind;
  assign out_o.result_role    = head.role;
  assign out_o.text_char      = head.text_char;
  assign out_o.number_value   = val_q[rd_q];
  assign out_o.number_clipped = head.clipped;
  assign out_o.error_code     = head.err_code;
  assign out_o.last_of_item   = head.last;

endmodule

`default_nettype wire

// ===== hdl/source_byte_tokenizer_core.sv =====
// top level of the source byte tokenizer
`default_nettype none

// Byte-serial tokenizer. One source byte is taken per cycle on in_i; each byte
// gives zero, one or two token results on out_o, in order, the final one
// flagged by last_of_item. A byte passes an input register and the scanner
// logic, then enters a four-entry result queue: its results are pushed into
// the queue once the queue has room for two and show on out_o from its head.
// The sustained rate is one byte per cycle as long as bytes give at most one
// result each and out_o takes every result; a byte that gives two results
// (a closed token plus the start of the next) fills the queue faster than one
// pop per cycle drains it, and in_i.ready drops while the queue has fewer
// than two free entries and a byte is held. Numbers saturate at 2^NUMBER_BITS-1
// with number_clipped set. After an error result the block drops all input
// until reset.
module source_byte_tokenizer_core #(
  parameter int unsigned NUMBER_BITS = stb_pkg::NUMBER_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stb_byte_if.sink  in_i,
  stb_tok_if.source out_o
);
  import stb_pkg::*;

  logic                   room;
  logic [1:0]             push_cnt;
  res_meta_t              res0, res1;
  logic [NUMBER_BITS-1:0] val0;

  // scanner with input register
  stb_scan #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.source_byte),
    .in_ready_o (in_i.ready),
    .room_i     (room),
    .push_cnt_o (push_cnt),
    .res0_o     (res0),
    .res1_o     (res1),
    .val0_o     (val0)
  );

  // result queue
  stb_resq #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .res0_i     (res0),
    .res1_i     (res1),
    .val0_i     (val0),
    .room_o     (room),
    .out_o      (out_o)
  );

  // an error is the final result ever: the queue is empty after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.result_role == ROLE_ERR) |=> !out_o.valid)
    else $error("result after an error transaction");

  // a clipped number carries the saturated value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.number_clipped) |-> (&out_o.number_value))
    else $error("clipped number not saturated");

  // an error result closes its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_role == ROLE_ERR) |-> out_o.last_of_item)
    else $error("error result not last of its byte");

  // nothing is pushed while the queue lacks room for a whole byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !room |-> (push_cnt == 2'd0))
    else $error("result push without queue room");

endmodule

`default_nettype wire

// ===== tb/source_byte_tokenizer_core_tb.sv =====
// self-checking testbench of the source byte tokenizer core
`timescale 1ns / 100ps

module source_byte_tokenizer_core_tb;
  import stb_pkg::*;

  localparam int unsigned NUM_W = NUMBER_BITS_DEF;
  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  localparam realtime CLK_HIGH = 6ns;
  localparam realtime CLK_LOW = 6ns;
  localparam int RESET_CYCLES = 11;
  localparam int DIRECTED_N = 25;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 16;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [7:0] SINGLE_OPS [0:10] = '{
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_COMMA, CH_PIPE,
    CH_LPAR, CH_RPAR, CH_LBRACE, CH_RBRACE
  };
  localparam logic [7:0] COMPARE_BYTES [0:3] = '{CH_EQ, CH_LT, CH_GT, CH_BANG};
  localparam logic [7:0] BLANKS [0:4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUM, SCAN_IDENT, SCAN_STR, SCAN_CMP, SCAN_HALT
  } scan_e;

  typedef struct packed {
    kind_e            kind;
    role_e            role;
    logic [7:0]       text_char;
    logic [NUM_W-1:0] value;
    logic             clipped;
    logic             err;
    logic             last;
  } token_t;

  localparam token_t NO_TOKEN = '0;

  // one directed source byte, with typed-in results where fixed is set
  typedef struct packed {
    logic [7:0] src;
    logic       fixed;
    logic [1:0] count;
    token_t     res_a;
    token_t     res_b;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  stb_byte_if byte_ch ();
  stb_tok_if #(.NUM_W(NUM_W)) tok_ch ();

  source_byte_tokenizer_core #(
    .NUMBER_BITS(NUM_W)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (tok_ch)
  );

  // tokenizer mirror state
  scan_e            scan_mode_q = SCAN_IDLE;
  kind_e            cmp_alone_q = KIND_STR;
  kind_e            cmp_pair_q = KIND_STR;
  logic [NUM_W-1:0] acc_q = '0;
  logic             acc_clip_q = 1'b0;

  token_t    step_tokens[$];
  token_t    tokens_expected[$];
  token_t    exp_tok;
  stim_row_t directed_rows[DIRECTED_N];

  int cycle_count = 0;
  int mismatch_count = 0;
  int accepted_bytes = 0;
  bit idle_on = 1'b1;
  bit pressure_req = 1'b0;

  // clock
  always begin
    #(CLK_LOW) clk_i = 1'b1;
    #(CLK_HIGH) clk_i = 1'b0;
  end

  function automatic token_t tok(input kind_e k, input role_e r, input logic [7:0] ch,
                                 input logic [NUM_W-1:0] v, input logic c, input logic e,
                                 input logic l);
    token_t t;
    t.kind = k;
    t.role = r;
    t.text_char = ch;
    t.value = v;
    t.clipped = c;
    t.err = e;
    t.last = l;
    return t;
  endfunction

  // character classes
  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR;
  endfunction

  function automatic bit single_kind(input logic [7:0] b, output kind_e k);
    bit hit;
    hit = 1'b1;
    case (b)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_PCT:    k = KIND_PCT;
      CH_COMMA:  k = KIND_COMMA;
      CH_PIPE:   k = KIND_PIPE;
      CH_LPAR:   k = KIND_LPAR;
      CH_RPAR:   k = KIND_RPAR;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LF:     k = KIND_NL;
      CH_SEMI:   k = KIND_SEMI;
      CH_NUL:    k = KIND_EOF;
      default: begin
        k = KIND_STR;
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  // kinds of a compare byte alone and with a trailing '='
  function automatic bit compare_kinds(input logic [7:0] b, output kind_e alone,
                                       output kind_e pair);
    bit hit;
    hit = 1'b1;
    case (b)
      CH_EQ: begin
        alone = KIND_ASSIGN;
        pair = KIND_EQEQ;
      end
      CH_LT: begin
        alone = KIND_LT;
        pair = KIND_LE;
      end
      CH_GT: begin
        alone = KIND_GT;
        pair = KIND_GE;
      end
      CH_BANG: begin
        alone = KIND_BANG;
        pair = KIND_NE;
      end
      default: begin
        alone = KIND_STR;
        pair = KIND_STR;
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  function automatic bit starts_token(input logic [7:0] b);
    kind_e k1, k2;
    return is_blank(b) || is_digit(b) || is_alpha(b) || b == CH_QUOTE ||
           compare_kinds(b, k1, k2) || single_kind(b, k1);
  endfunction

  // true if this byte would send the tokenizer into its halted state
  function automatic bit byte_halts(input logic [7:0] b);
    return (scan_mode_q == SCAN_STR) ? (b == CH_NUL)
                                     : (scan_mode_q != SCAN_HALT && !starts_token(b));
  endfunction

  // handle a byte as the start of a new token
  function automatic void scan_from_idle(input logic [7:0] b);
    kind_e k, k2;
    scan_mode_q = SCAN_IDLE;
    if (is_blank(b)) begin
      scan_mode_q = SCAN_IDLE;
    end else if (is_digit(b)) begin
      acc_q = NUM_W'(b - CH_ZERO);
      acc_clip_q = 1'b0;
      scan_mode_q = SCAN_NUM;
    end else if (is_alpha(b)) begin
      scan_mode_q = SCAN_IDENT;
      step_tokens.push_back(tok(KIND_IDENT, ROLE_TEXT, b, '0, 1'b0, 1'b0, 1'b0));
    end else if (b == CH_QUOTE) begin
      scan_mode_q = SCAN_STR;
    end else if (compare_kinds(b, k, k2)) begin
      cmp_alone_q = k;
      cmp_pair_q = k2;
      scan_mode_q = SCAN_CMP;
    end else if (single_kind(b, k)) begin
      step_tokens.push_back(tok(k, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b0));
    end else begin
      scan_mode_q = SCAN_HALT;
      step_tokens.push_back(tok(KIND_STR, ROLE_ERR, 8'h00, '0, 1'b0, ERR_UNKNOWN, 1'b0));
    end
  endfunction

  // results that one source byte causes, into step_tokens
  function automatic void scan_byte(input logic [7:0] b);
    longint unsigned digit;
    token_t t;
    step_tokens.delete();
    case (scan_mode_q)
      SCAN_HALT: begin
      end
      SCAN_NUM: begin
        if (is_digit(b)) begin
          digit = 64'(b - CH_ZERO);
          if (64'(acc_q) > (64'(NUM_MAX) - digit) / 10) begin
            acc_q = NUM_MAX;
            acc_clip_q = 1'b1;
          end else begin
            acc_q = NUM_W'(64'(acc_q) * 10 + digit);
          end
        end else begin
          step_tokens.push_back(tok(KIND_NUM, ROLE_WHOLE, 8'h00, acc_q, acc_clip_q, 1'b0,
                                    1'b0));
          scan_from_idle(b);
        end
      end
      SCAN_IDENT: begin
        if (is_alpha(b) || is_digit(b)) begin
          step_tokens.push_back(tok(KIND_IDENT, ROLE_TEXT, b, '0, 1'b0, 1'b0, 1'b0));
        end else begin
          step_tokens.push_back(tok(KIND_IDENT, ROLE_END, 8'h00, '0, 1'b0, 1'b0, 1'b0));
          scan_from_idle(b);
        end
      end
      SCAN_STR: begin
        if (b == CH_QUOTE) begin
          scan_mode_q = SCAN_IDLE;
          step_tokens.push_back(tok(KIND_STR, ROLE_END, 8'h00, '0, 1'b0, 1'b0, 1'b0));
        end else if (b == CH_NUL) begin
          scan_mode_q = SCAN_HALT;
          step_tokens.push_back(tok(KIND_STR, ROLE_ERR, 8'h00, '0, 1'b0, ERR_UNTERM, 1'b0));
        end else begin
          step_tokens.push_back(tok(KIND_STR, ROLE_TEXT, b, '0, 1'b0, 1'b0, 1'b0));
        end
      end
      SCAN_CMP: begin
        if (b == CH_EQ) begin
          scan_mode_q = SCAN_IDLE;
          step_tokens.push_back(tok(cmp_pair_q, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b0));
        end else begin
          step_tokens.push_back(tok(cmp_alone_q, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b0));
          scan_from_idle(b);
        end
      end
      default: begin
        scan_from_idle(b);
      end
    endcase
    // flag the final result of this byte
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
  endfunction

  // offer one byte, with an optional gap, and mirror it once the transaction completes
  task automatic offer_byte(input logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.source_byte <= b;
    @(posedge clk_i);
    while (byte_ch.ready !== 1'b1) @(posedge clk_i);
    accepted_bytes++;
    scan_byte(b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_byte(b);
    foreach (step_tokens[i]) tokens_expected.push_back(step_tokens[i]);
  endtask

  function automatic logic [7:0] random_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? 8'(CH_UP_A + $urandom_range(0, 25))
                                : 8'(CH_LO_A + $urandom_range(0, 25));
  endfunction

  // one well-formed token with random content, or now and then a stray byte
  task automatic send_random_token();
    int pick, len;
    logic [7:0] b;
    pick = $urandom_range(0, 19);
    if (pick <= 3) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      repeat (len) send_byte(random_digit());
    end else if (pick <= 7) begin
      send_byte(random_letter());
      repeat ($urandom_range(0, 6))
        send_byte($urandom_range(0, 3) == 0 ? random_digit() : random_letter());
    end else if (pick <= 10) begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
        send_byte(b);
      end
      send_byte(CH_QUOTE);
    end else if (pick <= 12) begin
      send_byte(SINGLE_OPS[$urandom_range(0, 10)]);
    end else if (pick <= 14) begin
      send_byte(COMPARE_BYTES[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1)) send_byte(CH_EQ);
    end else if (pick == 15) begin
      send_byte(BLANKS[$urandom_range(0, 4)]);
    end else if (pick == 16) begin
      send_byte($urandom_range(0, 1) ? CH_LF : CH_SEMI);
    end else if (pick == 17) begin
      // close a string left open by a stray quote before the eof
      if (scan_mode_q == SCAN_STR) send_byte(CH_QUOTE);
      send_byte(CH_NUL);
    end else begin
      do b = 8'($urandom_range(0, 255)); while (byte_halts(b));
      send_byte(b);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare every result transaction with the oldest expected token
  always @(posedge clk_i) begin
    if (rst_ni && tok_ch.valid === 1'b1 && tok_ch.ready === 1'b1) begin
      if (tokens_expected.size() == 0) begin
        $error("result with no token expected: kind %0d role %0d",
               tok_ch.token_kind, tok_ch.result_role);
        mismatch_count++;
      end else begin
        exp_tok = tokens_expected.pop_front();
        check_field("token_kind", 64'(exp_tok.kind), 64'(tok_ch.token_kind));
        check_field("result_role", 64'(exp_tok.role), 64'(tok_ch.result_role));
        check_field("text_char", 64'(exp_tok.text_char), 64'(tok_ch.text_char));
        check_field("number_value", 64'(exp_tok.value), 64'(tok_ch.number_value));
        check_field("number_clipped", 64'(exp_tok.clipped), 64'(tok_ch.number_clipped));
        check_field("error_code", 64'(exp_tok.err), 64'(tok_ch.error_code));
        check_field("last_of_item", 64'(exp_tok.last), 64'(tok_ch.last_of_item));
      end
    end
  end

  // result sink: random stall bursts and one long hold-off
  initial begin : result_sink
    int stall_left, hold_left;
    bit pressure_done;
    stall_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    tok_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (pressure_req && !pressure_done) begin
        hold_left = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        tok_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("source_byte_tokenizer_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int row_idx;
    logic [7:0] b;
    byte_ch.valid = 1'b0;
    byte_ch.source_byte = 8'h00;

    // directed table: eof, an operator, a saturating number closed by ';', a number
    // cut off by eof, identifier, compare pair and lone compare, string with a high byte
    directed_rows[0] = '{CH_NUL, 1'b1, 2'd1,
                         tok(KIND_EOF, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b1), NO_TOKEN};
    directed_rows[1] = '{CH_PLUS, 1'b1, 2'd1,
                         tok(KIND_PLUS, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b1), NO_TOKEN};
    for (row_idx = 2; row_idx < 12; row_idx++)
      directed_rows[row_idx] = '{CH_NINE, 1'b1, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[12] = '{CH_SEMI, 1'b1, 2'd2,
                          tok(KIND_NUM, ROLE_WHOLE, 8'h00, NUM_MAX, 1'b1, 1'b0, 1'b0),
                          tok(KIND_SEMI, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b1)};
    directed_rows[13] = '{CH_ZERO, 1'b1, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[14] = '{CH_NUL, 1'b1, 2'd2,
                          tok(KIND_NUM, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b0),
                          tok(KIND_EOF, ROLE_WHOLE, 8'h00, '0, 1'b0, 1'b0, 1'b1)};
    directed_rows[15] = '{CH_UP_A, 1'b1, 2'd1,
                          tok(KIND_IDENT, ROLE_TEXT, CH_UP_A, '0, 1'b0, 1'b0, 1'b1),
                          NO_TOKEN};
    directed_rows[16] = '{CH_LO_Z, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[17] = '{CH_LT, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[18] = '{CH_EQ, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[19] = '{CH_BANG, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[20] = '{CH_CR, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[21] = '{CH_QUOTE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[22] = '{8'hFF, 1'b1, 2'd1,
                          tok(KIND_STR, ROLE_TEXT, 8'hFF, '0, 1'b0, 1'b0, 1'b1), NO_TOKEN};
    directed_rows[23] = '{CH_QUOTE, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    directed_rows[24] = '{CH_LF, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};

    // reset
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    for (row_idx = 0; row_idx < DIRECTED_N; row_idx++) begin
      if (directed_rows[row_idx].fixed) begin
        offer_byte(directed_rows[row_idx].src);
        if (directed_rows[row_idx].count > 0)
          tokens_expected.push_back(directed_rows[row_idx].res_a);
        if (directed_rows[row_idx].count > 1)
          tokens_expected.push_back(directed_rows[row_idx].res_b);
      end else begin
        send_byte(directed_rows[row_idx].src);
      end
    end

    // random token stream, with a quiet stretch in the middle and at the end
    while (accepted_bytes < DIRECTED_N + RANDOM_ITEMS) begin
      idle_on = !((accepted_bytes >= 900 && accepted_bytes < 1100) ||
                  accepted_bytes >= DIRECTED_N + RANDOM_ITEMS - 300);
      if (accepted_bytes >= 400) pressure_req = 1'b1;
      send_random_token();
    end

    // end with one fatal error, then bytes that the halted block drops
    if ($urandom_range(0, 1)) begin
      if (scan_mode_q == SCAN_STR) send_byte(CH_QUOTE);
      do b = 8'($urandom_range(0, 255)); while (starts_token(b));
      send_byte(b);
    end else begin
      if (scan_mode_q != SCAN_STR) send_byte(CH_QUOTE);
      send_byte(random_letter());
      send_byte(CH_NUL);
    end
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;

    // drain
    while (tokens_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && tokens_expected.size() == 0)
      $display("source_byte_tokenizer_core regression: pass");
    else
      $display("source_byte_tokenizer_core regression: fail");
    $finish;
  end

endmodule
